// ===== sv/mpc_pkg.sv =====
`default_nettype none

package mpc_pkg;

  // Command codes of the input word
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_MANUAL = 2'd2;

  // Bridge drive directions
  localparam logic [1:0] DIR_COAST   = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;
  localparam logic [1:0] DIR_BRAKE   = 2'd3;

  // Status codes of the result word
  localparam logic [2:0] ST_IDLE        = 3'd0;
  localparam logic [2:0] ST_MOVING      = 3'd1;
  localparam logic [2:0] ST_REACHED     = 3'd2;
  localparam logic [2:0] ST_TIMEOUT     = 3'd3;
  localparam logic [2:0] ST_STALLED_NR  = 3'd4;
  localparam logic [2:0] ST_STALLED_FAR = 3'd5;

  // Configuration register indexes
  localparam int         REG_IDX_W      = 3;
  localparam logic [2:0] REG_SPAN_MIN   = 3'd0;
  localparam logic [2:0] REG_SPAN_MAX   = 3'd1;
  localparam logic [2:0] REG_INVERT_DIR = 3'd2;
  localparam logic [2:0] REG_DEADBAND   = 3'd3;
  localparam logic [2:0] REG_FINE_ZONE  = 3'd4;
  localparam logic [2:0] REG_SLOW_DUTY  = 3'd5;
  localparam logic [2:0] REG_FAST_DUTY  = 3'd6;

  // Fixed field widths
  localparam int DUTY_W = 8;
  localparam int TGT_W  = 14;
  localparam int TIME_W = 32;

  localparam logic [DUTY_W-1:0] FULL_DUTY   = 8'hFF;
  localparam logic [TGT_W-1:0]  TARGET_FULL = 14'd10000;
  localparam int                MOVE_STEP   = 8;

  // Exact floor(p / 10000) for p < 2^30: (p * DIV_MUL) >> DIV_SHIFT
  localparam int                  DIV_MUL_W = 31;
  localparam int                  DIV_SHIFT = 44;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL  = 31'd1759218605;

  typedef struct packed {
    logic [DUTY_W-1:0] a;
    logic [DUTY_W-1:0] b;
  } duty_pair_t;

endpackage

`default_nettype wire

// ===== sv/motor_pot_position_controller_unit.sv =====
// An accepted word passes the input stage and then the result register to the result port.
// Throughput: one word per cycle unless out_stall holds a full result or
// cfg_valid is high; the target product is formed in the input stage and its
// reciprocal division by 10000 in the result stage.
// Reset (rst_n low, synchronous): no move active, duties coasting, both
// stages empty, configuration back to its default values.
`default_nettype none

module motor_pot_position_controller_unit #(
  parameter int ADC_BITS    = 12,
  parameter int STALL_LIMIT = 30
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_command,
  input  wire logic [mpc_pkg::TGT_W-1:0]         in_target_hundredths,
  input  wire logic [mpc_pkg::TIME_W-1:0]        in_timeout_ms,
  input  wire logic [mpc_pkg::TIME_W-1:0]        in_time_ms,
  input  wire logic [ADC_BITS-1:0]               in_adc_sample,
  input  wire logic [1:0]                        in_drive_dir,
  input  wire logic [mpc_pkg::DUTY_W-1:0]        in_drive_duty,
  input  wire logic                              in_fast_decay,

  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [mpc_pkg::DUTY_W-1:0]             out_ain1_duty,
  output logic [mpc_pkg::DUTY_W-1:0]             out_ain2_duty,
  output logic [2:0]                             out_status,
  output logic                                   out_move_active,

  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mpc_pkg::REG_IDX_W-1:0]     cfg_index,
  input  wire logic [ADC_BITS-1:0]               cfg_data
);

  localparam int PROD_W = mpc_pkg::TGT_W + ADC_BITS;
  localparam int QMUL_W = PROD_W + mpc_pkg::DIV_MUL_W;
  localparam int CNT_W  = $clog2(STALL_LIMIT + 2);
  localparam int DW     = mpc_pkg::DUTY_W;
  localparam int TW     = mpc_pkg::TIME_W;

  // Map direction, duty and decay onto the two bridge inputs
  function automatic mpc_pkg::duty_pair_t drive_f(
    input logic [1:0]    dir,
    input logic [DW-1:0] duty,
    input logic          fast,
    input logic          inv
  );
    logic [1:0]         d;
    mpc_pkg::duty_pair_t p;
    d = dir;
    if (inv && (dir == mpc_pkg::DIR_FORWARD)) d = mpc_pkg::DIR_REVERSE;
    if (inv && (dir == mpc_pkg::DIR_REVERSE)) d = mpc_pkg::DIR_FORWARD;
    p.a = '0;
    p.b = '0;
    case (d)
      mpc_pkg::DIR_FORWARD: begin
        p.a = fast ? duty : mpc_pkg::FULL_DUTY;
        p.b = fast ? '0 : mpc_pkg::FULL_DUTY - duty;
      end
      mpc_pkg::DIR_REVERSE: begin
        p.a = fast ? '0 : mpc_pkg::FULL_DUTY - duty;
        p.b = fast ? duty : mpc_pkg::FULL_DUTY;
      end
      mpc_pkg::DIR_BRAKE: begin
        p.a = mpc_pkg::FULL_DUTY;
        p.b = mpc_pkg::FULL_DUTY;
      end
      default: begin
        p.a = '0;
        p.b = '0;
      end
    endcase
    return p;
  endfunction

  // Configuration registers
  logic [ADC_BITS-1:0] span_min_r, span_max_r, deadband_r, fine_zone_r;
  logic                invert_dir_r;
  logic [DW-1:0]       slow_duty_r, fast_duty_r;

  // Move state
  logic                moving_r, moving_nxt;
  logic [ADC_BITS-1:0] goal_adc_r, goal_adc_nxt;
  logic [TW-1:0]       start_stamp_r, start_stamp_nxt;
  logic [TW-1:0]       move_limit_r, move_limit_nxt;
  logic [ADC_BITS-1:0] prev_reading_r, prev_reading_nxt;
  logic [CNT_W-1:0]    stall_ticks_r, stall_ticks_nxt;
  logic [DW-1:0]       held_duty_a_r, held_duty_a_nxt;
  logic [DW-1:0]       held_duty_b_r, held_duty_b_nxt;
  logic [2:0]          status_nxt;

  // Input stage
  logic                s1_valid_r;
  logic [1:0]          s1_command_r;
  logic [PROD_W-1:0]   s1_prod_r;
  logic [TW-1:0]       s1_timeout_r, s1_time_r;
  logic [ADC_BITS-1:0] s1_adc_r;
  logic [1:0]          s1_dir_r;
  logic [DW-1:0]       s1_duty_r;
  logic                s1_decay_r;

  // Result register
  logic                out_valid_r;
  logic [DW-1:0]       out_ain1_r, out_ain2_r;
  logic [2:0]          out_status_r;
  logic                out_active_r;

  logic out_en, s1_go, in_take;

  // Handshake: the result register frees the input stage when taken
  assign out_en    = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && out_en;
  assign in_stall  = (s1_valid_r && !out_en) || cfg_valid;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_min_r   <= '0;
      span_max_r   <= '1;
      invert_dir_r <= 1'b0;
      deadband_r   <= ADC_BITS'(20);
      fine_zone_r  <= ADC_BITS'(200);
      slow_duty_r  <= DW'(100);
      fast_duty_r  <= DW'(200);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mpc_pkg::REG_SPAN_MIN:   span_min_r   <= cfg_data;
        mpc_pkg::REG_SPAN_MAX:   span_max_r   <= cfg_data;
        mpc_pkg::REG_INVERT_DIR: invert_dir_r <= cfg_data[0];
        mpc_pkg::REG_DEADBAND:   deadband_r   <= cfg_data;
        mpc_pkg::REG_FINE_ZONE:  fine_zone_r  <= cfg_data;
        mpc_pkg::REG_SLOW_DUTY:  slow_duty_r  <= cfg_data[DW-1:0];
        mpc_pkg::REG_FAST_DUTY:  fast_duty_r  <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the target and scale it by the span
  logic [mpc_pkg::TGT_W-1:0] t_sat;
  logic [ADC_BITS-1:0]       span_range;
  logic [PROD_W-1:0]         prod;

  always_comb begin
    t_sat = (in_target_hundredths > mpc_pkg::TARGET_FULL) ? mpc_pkg::TARGET_FULL
                                                          : in_target_hundredths;
    span_range = (span_max_r > span_min_r) ? (span_max_r - span_min_r) : '0;
    prod = PROD_W'(t_sat) * PROD_W'(span_range);
  end

  // Load the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take || (s1_valid_r && !out_en);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_command_r <= in_command;
      s1_prod_r    <= prod;
      s1_timeout_r <= in_timeout_ms;
      s1_time_r    <= in_time_ms;
      s1_adc_r     <= in_adc_sample;
      s1_dir_r     <= in_drive_dir;
      s1_duty_r    <= in_drive_duty;
      s1_decay_r   <= in_fast_decay;
    end
  end

  // Result stage: divide by 10000 and run the controller
  logic [QMUL_W-1:0]   qmul;
  logic [ADC_BITS-1:0] quot;
  logic [TW-1:0]       elapsed;
  logic                goal_above;
  logic [ADC_BITS-1:0] aerr, delta;
  logic                coarse, near;
  logic [CNT_W-1:0]    ticks_inc;
  mpc_pkg::duty_pair_t pair;

  always_comb begin
    qmul = QMUL_W'(s1_prod_r) * QMUL_W'(mpc_pkg::DIV_MUL);
    quot = qmul[mpc_pkg::DIV_SHIFT +: ADC_BITS];

    elapsed    = s1_time_r - start_stamp_r;
    goal_above = goal_adc_r > s1_adc_r;
    aerr       = goal_above ? (goal_adc_r - s1_adc_r) : (s1_adc_r - goal_adc_r);
    delta      = (s1_adc_r > prev_reading_r) ? (s1_adc_r - prev_reading_r)
                                             : (prev_reading_r - s1_adc_r);
    coarse     = aerr >= fine_zone_r;
    near       = {1'b0, aerr} <= {deadband_r, 1'b0};
    ticks_inc  = stall_ticks_r + 1'b1;
    pair       = '0;

    moving_nxt       = moving_r;
    goal_adc_nxt     = goal_adc_r;
    start_stamp_nxt  = start_stamp_r;
    move_limit_nxt   = move_limit_r;
    prev_reading_nxt = prev_reading_r;
    stall_ticks_nxt  = stall_ticks_r;
    held_duty_a_nxt  = held_duty_a_r;
    held_duty_b_nxt  = held_duty_b_r;
    status_nxt       = moving_r ? mpc_pkg::ST_MOVING : mpc_pkg::ST_IDLE;

    case (s1_command_r)
      mpc_pkg::CMD_START: begin
        goal_adc_nxt     = span_min_r + quot;
        start_stamp_nxt  = s1_time_r;
        move_limit_nxt   = s1_timeout_r;
        stall_ticks_nxt  = '0;
        prev_reading_nxt = '0;
        moving_nxt       = 1'b1;
        status_nxt       = mpc_pkg::ST_MOVING;
      end
      mpc_pkg::CMD_SAMPLE: begin
        if (moving_r) begin
          if (elapsed > move_limit_r) begin
            // Out of time: coast and end the move
            moving_nxt      = 1'b0;
            held_duty_a_nxt = '0;
            held_duty_b_nxt = '0;
            status_nxt      = mpc_pkg::ST_TIMEOUT;
          end else if (aerr <= deadband_r) begin
            moving_nxt      = 1'b0;
            held_duty_a_nxt = '0;
            held_duty_b_nxt = '0;
            status_nxt      = mpc_pkg::ST_REACHED;
          end else if (coarse && (delta < ADC_BITS'(mpc_pkg::MOVE_STEP))
                       && (ticks_inc > CNT_W'(STALL_LIMIT))) begin
            // Stalled in the coarse zone: hold the reading, coast
            stall_ticks_nxt = ticks_inc;
            moving_nxt      = 1'b0;
            held_duty_a_nxt = '0;
            held_duty_b_nxt = '0;
            status_nxt      = near ? mpc_pkg::ST_STALLED_NR : mpc_pkg::ST_STALLED_FAR;
          end else begin
            // Advance toward the goal
            if (coarse && (delta < ADC_BITS'(mpc_pkg::MOVE_STEP))) begin
              stall_ticks_nxt = ticks_inc;
            end else begin
              stall_ticks_nxt = '0;
            end
            prev_reading_nxt = s1_adc_r;
            pair = drive_f(goal_above ? mpc_pkg::DIR_FORWARD : mpc_pkg::DIR_REVERSE,
                           coarse ? fast_duty_r : slow_duty_r, 1'b1, invert_dir_r);
            held_duty_a_nxt = pair.a;
            held_duty_b_nxt = pair.b;
            status_nxt      = mpc_pkg::ST_MOVING;
          end
        end
      end
      mpc_pkg::CMD_MANUAL: begin
        pair = drive_f(s1_dir_r, s1_duty_r, s1_decay_r, invert_dir_r);
        held_duty_a_nxt = pair.a;
        held_duty_b_nxt = pair.b;
      end
      default: ;
    endcase
  end

  // Commit the move state when the word leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r       <= 1'b0;
      goal_adc_r     <= '0;
      start_stamp_r  <= '0;
      move_limit_r   <= '0;
      prev_reading_r <= '0;
      stall_ticks_r  <= '0;
      held_duty_a_r  <= '0;
      held_duty_b_r  <= '0;
    end else if (s1_go) begin
      moving_r       <= moving_nxt;
      goal_adc_r     <= goal_adc_nxt;
      start_stamp_r  <= start_stamp_nxt;
      move_limit_r   <= move_limit_nxt;
      prev_reading_r <= prev_reading_nxt;
      stall_ticks_r  <= stall_ticks_nxt;
      held_duty_a_r  <= held_duty_a_nxt;
      held_duty_b_r  <= held_duty_b_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_go || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_ain1_r   <= held_duty_a_nxt;
      out_ain2_r   <= held_duty_b_nxt;
      out_status_r <= status_nxt;
      out_active_r <= moving_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ain1_duty   = out_ain1_r;
  assign out_ain2_duty   = out_ain2_r;
  assign out_status      = out_status_r;
  assign out_move_active = out_active_r;

endmodule

`default_nettype wire
